FILE: hdl/lidar_point_curvature_unit_assert.svh
// Assertion macros for the lidar point curvature unit.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef LIDAR_POINT_CURVATURE_UNIT_ASSERT_SVH
`define LIDAR_POINT_CURVATURE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define LPC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpc assertion failed");
`define LPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpc assertion failed");
`else
`define LPC_ASSERT_IMPL(lbl, ante, cons)
`define LPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/lpc_pkg.sv
// Shared types and constants of the lidar point curvature unit.
// No dependencies.
`timescale 1ns / 1ps
package lpc_pkg;
  localparam int CNT_W      = 7;
  localparam int SQ_OPS     = 6;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_SUM, ST_SQR, ST_DRAIN, ST_DEN, ST_DINIT,
    ST_DIV, ST_SQI, ST_SQRT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic             load_in;
    logic             sum_clr;
    logic             sum_en;
    logic             sq_issue;
    logic [2:0]       sq_sel;
    logic [1:0]       sq_step;
    logic             den_ld;
    logic             div_init;
    logic             div_en;
    logic             sqrt_init;
    logic             sqrt_en;
    logic             out_ld;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_ready;
    logic full;
  } status_t;
endpackage

FILE: hdl/lpc_in_if.sv
// Input point channel: valid/ready handshake plus point payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface lpc_in_if;
  logic               valid;
  logic               ready;
  logic               scan_start;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
  modport source (output valid, scan_start, px, py, pz, input ready);
  modport sink   (input valid, scan_start, px, py, pz, output ready);
endinterface

FILE: hdl/lpc_out_if.sv
// Result channel: valid/ready handshake plus centre point and curvature.
// Depends on nothing.
`timescale 1ns / 1ps
interface lpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cz;
  logic        [31:0] curvature;
  logic               zero_range;
  modport source (output valid, cx, cy, cz, curvature, zero_range, input ready);
  modport sink   (input valid, cx, cy, cz, curvature, zero_range, output ready);
endinterface

FILE: hdl/lpc_ctrl.sv
// Sequencer of the curvature unit: steps the datapath through sum, squares,
// division and square root. Depends on lpc_pkg.
`timescale 1ns / 1ps
module lpc_ctrl #(
  parameter int HALF_WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  lpc_pkg::status_t status,
  output lpc_pkg::cmd_t    cmd,
  output logic             in_ready,
  output logic             out_valid
);
  localparam int WIN = 2 * HALF_WIDTH + 1;

  lpc_pkg::state_t state, state_next;
  logic [lpc_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [2:0] sel, sel_next;
  logic [1:0] step, step_next;
  logic sq_last;

  assign sq_last = (sel == 3'(lpc_pkg::SQ_OPS - 1)) && (step == 2'd2);

  always_comb begin
    state_next = state;
    unique case (state)
      lpc_pkg::ST_IDLE:  if (status.in_valid) state_next = lpc_pkg::ST_CHECK;
      lpc_pkg::ST_CHECK: state_next = status.full ? lpc_pkg::ST_SUM : lpc_pkg::ST_IDLE;
      lpc_pkg::ST_SUM:   if (cnt == lpc_pkg::CNT_W'(WIN - 1)) state_next = lpc_pkg::ST_SQR;
      lpc_pkg::ST_SQR:   if (sq_last) state_next = lpc_pkg::ST_DRAIN;
      lpc_pkg::ST_DRAIN: state_next = lpc_pkg::ST_DEN;
      lpc_pkg::ST_DEN:   state_next = lpc_pkg::ST_DINIT;
      lpc_pkg::ST_DINIT: state_next = lpc_pkg::ST_DIV;
      lpc_pkg::ST_DIV: begin
        if (cnt == lpc_pkg::CNT_W'(lpc_pkg::DIV_STEPS - 1)) state_next = lpc_pkg::ST_SQI;
      end
      lpc_pkg::ST_SQI:   state_next = lpc_pkg::ST_SQRT;
      lpc_pkg::ST_SQRT: begin
        if (cnt == lpc_pkg::CNT_W'(lpc_pkg::SQRT_STEPS - 1)) state_next = lpc_pkg::ST_EMIT;
      end
      lpc_pkg::ST_EMIT:  if (!out_valid) state_next = lpc_pkg::ST_IDLE;
      default:           state_next = lpc_pkg::ST_IDLE;
    endcase
  end

  // step counters restart whenever the state changes
  always_comb begin
    cnt_next  = (state_next != state) ? '0 : cnt + 1'b1;
    sel_next  = sel;
    step_next = step;
    if (state != lpc_pkg::ST_SQR) begin
      sel_next  = '0;
      step_next = '0;
    end else if (step == 2'd2) begin
      step_next = '0;
      sel_next  = sel + 1'b1;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.cnt       = cnt;
    cmd.sq_sel    = sel;
    cmd.sq_step   = step;
    in_ready      = 1'b0;
    unique case (state)
      lpc_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = status.in_valid;
      end
      lpc_pkg::ST_CHECK: cmd.sum_clr   = 1'b1;
      lpc_pkg::ST_SUM:   cmd.sum_en    = 1'b1;
      lpc_pkg::ST_SQR:   cmd.sq_issue  = 1'b1;
      lpc_pkg::ST_DEN:   cmd.den_ld    = 1'b1;
      lpc_pkg::ST_DINIT: cmd.div_init  = 1'b1;
      lpc_pkg::ST_DIV:   cmd.div_en    = 1'b1;
      lpc_pkg::ST_SQI:   cmd.sqrt_init = 1'b1;
      lpc_pkg::ST_SQRT:  cmd.sqrt_en   = 1'b1;
      lpc_pkg::ST_EMIT:  cmd.out_ld    = !out_valid;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpc_pkg::ST_IDLE;
      cnt       <= '0;
      sel       <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sel   <= sel_next;
      step  <= step_next;
      if (cmd.out_ld) out_valid <= 1'b1;
      else if (status.out_ready) out_valid <= 1'b0;
    end
  end
endmodule

FILE: hdl/lpc_datapath.sv
// Datapath of the curvature unit: point window, difference sums, split
// squarer, restoring divider, bit-serial square root, result register.
// Depends on lpc_pkg.
`timescale 1ns / 1ps
module lpc_datapath #(
  parameter int HALF_WIDTH = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  lpc_pkg::cmd_t      cmd,
  input  logic               scan_start,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  output logic               full,
  output logic signed [31:0] cx,
  output logic signed [31:0] cy,
  output logic signed [31:0] cz,
  output logic        [31:0] curvature,
  output logic               zero_range
);
  localparam int WIN = 2 * HALF_WIDTH + 1;
  localparam int KW  = $clog2(WIN);
  localparam int FW  = $clog2(WIN + 1);
  localparam int DB  = 33 + $clog2(WIN);
  localparam int HB  = (DB + 1) / 2;
  localparam int PW  = 2 * HB;
  localparam int SW  = 2 * DB + 2;
  localparam int W2  = WIN * WIN;
  localparam int DW  = 64 + $clog2(W2 + 1);
  localparam int RW  = DW + 1;
  localparam logic [DW-1:0] W2_C = DW'(W2);

  logic [31:0] wx [WIN];
  logic [31:0] wy [WIN];
  logic [31:0] wz [WIN];
  logic [FW-1:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.load_in) begin
      if (scan_start) fill <= FW'(1);
      else if (fill != FW'(WIN)) fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN; i++) begin
        wx[i] <= '0;
        wy[i] <= '0;
        wz[i] <= '0;
      end
    end else if (cmd.load_in) begin
      for (int i = 0; i < WIN - 1; i++) begin
        wx[i] <= wx[i+1];
        wy[i] <= wy[i+1];
        wz[i] <= wz[i+1];
      end
      wx[WIN-1] <= px;
      wy[WIN-1] <= py;
      wz[WIN-1] <= pz;
    end
  end

  assign full = (fill == FW'(WIN));

  // difference sums, one window point per cycle
  logic [31:0] ccx, ccy, ccz;
  logic [KW-1:0] k;
  logic signed [32:0] dfx, dfy, dfz;
  logic signed [DB-1:0] dsx, dsy, dsz;

  assign ccx = wx[HALF_WIDTH];
  assign ccy = wy[HALF_WIDTH];
  assign ccz = wz[HALF_WIDTH];
  assign k   = cmd.cnt[KW-1:0];
  assign dfx = $signed({ccx[31], ccx}) - $signed({wx[k][31], wx[k]});
  assign dfy = $signed({ccy[31], ccy}) - $signed({wy[k][31], wy[k]});
  assign dfz = $signed({ccz[31], ccz}) - $signed({wz[k][31], wz[k]});

  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      dsx <= '0;
      dsy <= '0;
      dsz <= '0;
    end else if (cmd.sum_en) begin
      dsx <= dsx + DB'(dfx);
      dsy <= dsy + DB'(dfy);
      dsz <= dsz + DB'(dfz);
    end
  end

  // squares from three half-width partial products each
  logic signed [DB-1:0] opnd;
  logic [DB-1:0] mag;
  logic [HB-1:0] m_lo, m_hi, mul_a, mul_b;
  logic [PW-1:0] prod;
  logic [1:0] prod_step;
  logic prod_v, prod_s;
  logic [SW-1:0] term, r2acc, sacc;

  always_comb begin
    case (cmd.sq_sel)
      3'd0:    opnd = DB'($signed(ccx));
      3'd1:    opnd = DB'($signed(ccy));
      3'd2:    opnd = DB'($signed(ccz));
      3'd3:    opnd = dsx;
      3'd4:    opnd = dsy;
      3'd5:    opnd = dsz;
      default: opnd = '0;
    endcase
  end

  assign mag   = opnd[DB-1] ? DB'(-opnd) : DB'(opnd);
  assign m_lo  = mag[HB-1:0];
  assign m_hi  = HB'(mag >> HB);
  assign mul_a = (cmd.sq_step == 2'd2) ? m_hi : m_lo;
  assign mul_b = (cmd.sq_step == 2'd0) ? m_lo : m_hi;

  always_ff @(posedge clk) begin
    if (rst) prod_v <= 1'b0;
    else     prod_v <= cmd.sq_issue;
    prod      <= PW'(mul_a) * PW'(mul_b);
    prod_step <= cmd.sq_step;
    prod_s    <= (cmd.sq_sel >= 3'd3);
  end

  always_comb begin
    case (prod_step)
      2'd0:    term = SW'(prod);
      2'd1:    term = SW'(prod) << (HB + 1);
      default: term = SW'(prod) << (2 * HB);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      r2acc <= '0;
      sacc  <= '0;
    end else if (prod_v) begin
      if (prod_s) sacc  <= sacc + term;
      else        r2acc <= r2acc + term;
    end
  end

  // the divider gives the low 64 bits of the quotient of (S << 48) by WIN^2 * R^2
  logic [63:0] r2;
  logic [DW-1:0] den;
  logic [RW-1:0] rem, rem2;
  logic [63:0] nb, quo;
  logic over;

  assign r2   = r2acc[63:0];
  assign rem2 = {rem[RW-2:0], nb[63]};

  always_ff @(posedge clk) begin
    if (cmd.den_ld) den <= DW'(r2) * W2_C;
    if (cmd.div_init) begin
      over <= RW'(sacc[SW-1:16]) >= RW'(den);
      rem  <= RW'(sacc[SW-1:16]);
      nb   <= {sacc[15:0], 48'd0};
      quo  <= '0;
    end else if (cmd.div_en) begin
      nb <= nb << 1;
      if (rem2 >= RW'(den)) begin
        rem <= rem2 - RW'(den);
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem2;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  // square root, one result bit per cycle
  logic [63:0] sv, sres, sbit, strial;
  assign strial = sres + sbit;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sv   <= quo;
      sres <= '0;
      sbit <= 64'd1 << 62;
    end else if (cmd.sqrt_en) begin
      sbit <= sbit >> 2;
      if (sv >= strial) begin
        sv   <= sv - strial;
        sres <= (sres >> 1) + sbit;
      end else begin
        sres <= sres >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      cx         <= $signed(ccx);
      cy         <= $signed(ccy);
      cz         <= $signed(ccz);
      zero_range <= (r2 == '0);
      curvature  <= ((r2 == '0) || over) ? 32'hFFFF_FFFF : sres[31:0];
    end
  end
endmodule

FILE: hdl/lidar_point_curvature_unit.sv
// Lidar scan-line point curvature unit (top level).
// Channel in_ch takes points of one scan line in order; scan_start marks the
// first point of a scan and empties the 2*HALF_WIDTH+1 point window.
// Channel out_ch gives the centre point of a full window with its curvature
// (units of 2^-24, saturated) and a zero-range flag.
// Both channels transfer on valid and ready high at a clock edge.
// A point that does not complete a window is only stored. A point that does
// is carried from acceptance to the result register through the window sum
// (one point per cycle), split-multiplier squares, a restoring divider and a
// bit-serial square root, all on one item.
// Results wait in an output register; a new point is accepted while a
// result waits, and the next result holds until the receiver takes it.
// Synchronous reset empties the window and drops any pending result.
// Depends on lpc_pkg, lpc_in_if, lpc_out_if, lpc_ctrl, lpc_datapath and lidar_point_curvature_unit_assert.svh.
`timescale 1ns / 1ps
`include "lidar_point_curvature_unit_assert.svh"
module lidar_point_curvature_unit #(
  parameter int HALF_WIDTH = 1
) (
  input logic      clk,
  input logic      rst,
  lpc_in_if.sink   in_ch,
  lpc_out_if.source out_ch
);
  lpc_pkg::cmd_t    cmd;
  lpc_pkg::status_t status;
  logic             full;

  assign status.in_valid  = in_ch.valid;
  assign status.out_ready = out_ch.ready;
  assign status.full      = full;

  lpc_ctrl #(.HALF_WIDTH(HALF_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  lpc_datapath #(.HALF_WIDTH(HALF_WIDTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .scan_start (in_ch.scan_start),
    .px         (in_ch.px),
    .py         (in_ch.py),
    .pz         (in_ch.pz),
    .full       (full),
    .cx         (out_ch.cx),
    .cy         (out_ch.cy),
    .cz         (out_ch.cz),
    .curvature  (out_ch.curvature),
    .zero_range (out_ch.zero_range)
  );

  `LPC_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `LPC_ASSERT_IMPL(a_zero_saturates, out_ch.valid && out_ch.zero_range, out_ch.curvature == '1)
  `LPC_ASSERT_IMPL(a_load_while_busy, $rose(out_ch.valid), $past(!in_ch.ready))
endmodule
